@@ hdl/lpc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lift position controller package
// Shared types, request and register codes, constants and small helpers.
// ----------------------------------------------------------------------------
package lpc_pkg;

  // Default width of the internal position arithmetic.
  localparam int POS_WIDTH_DEF = 16;

  // Request kinds carried in the input tuser; the spare code acts as a tick.
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_SET   = 2'd1;
  localparam logic [1:0] REQ_HOME  = 2'd2;
  localparam logic [1:0] REQ_SPARE = 2'd3;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 15;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FAR_THRESH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UP_FAST    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UP_SLOW    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DOWN_FAST  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DOWN_SLOW  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPEED  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED  = 3'd7;

  // Register reset values.
  localparam logic [9:0]  RST_DEADBAND   = 10'd15;
  localparam logic [14:0] RST_FAR_THRESH = 15'd1000;
  localparam logic [6:0]  RST_UP_FAST    = 7'd100;
  localparam logic [6:0]  RST_UP_SLOW    = 7'd60;
  localparam logic [6:0]  RST_DOWN_FAST  = 7'd40;
  localparam logic [6:0]  RST_DOWN_SLOW  = 7'd20;
  localparam logic [6:0]  RST_MIN_SPEED  = 7'd30;
  localparam logic [6:0]  RST_MAX_SPEED  = 7'd60;

  // Homing speeds and scaling.
  localparam logic [6:0]  PCT_FULL       = 7'd100;
  localparam logic [6:0]  HOME_FAST_PCT  = 7'd100;
  localparam logic [6:0]  HOME_SLOW_PCT  = 7'd10;
  localparam logic [12:0] DUTY_PER_SPEED = 13'd75;

  // Target scaling p*3000/1326 = p*1500/663, done as a reciprocal multiply.
  // Exact for every 12-bit p with a 22-bit shift.
  localparam int TGT_SHIFT = 22;
  localparam logic [23:0] TGT_RECIP =
      24'(((64'd1 << TGT_SHIFT) * 64'd1500 + 64'd662) / 64'd663);
  localparam int TGT_Q_W = 14;

  // Division of a product below 10001 by 100, by reciprocal multiply.
  localparam int DIV100_SHIFT = 19;
  localparam logic [12:0] DIV100_RECIP = 13'd5243;

  // Homing and run phases, one-hot.
  typedef enum logic [4:0] {
    PH_IDLE        = 5'b00001,
    PH_UP_TOP      = 5'b00010,
    PH_DOWN_BOTTOM = 5'b00100,
    PH_UP_RELEASE  = 5'b01000,
    PH_RUN         = 5'b10000
  } phase_t;

  // Configuration register set.
  typedef struct packed {
    logic [9:0]  deadband;
    logic [14:0] far_threshold;
    logic [6:0]  up_fast_pct;
    logic [6:0]  up_slow_pct;
    logic [6:0]  down_fast_pct;
    logic [6:0]  down_slow_pct;
    logic [6:0]  min_speed;
    logic [6:0]  max_speed;
  } cfg_t;

  // Controller decision handed on to the speed stages.
  typedef struct packed {
    logic [13:0] prod;
    logic        stop;
    logic        direction_down;
    logic        arrived;
    logic        homing_busy;
    logic [15:0] position;
  } ctrl_res_t;

  // Clamp a 7-bit percentage or speed to 100.
  function automatic logic [6:0] sat100(input logic [6:0] v);
    logic [6:0] r;
    r = (v > PCT_FULL) ? PCT_FULL : v;
    return r;
  endfunction

endpackage

@@ hdl/lpc_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lift position controller configuration registers
// Write-only register set, loaded through the index/data write port.
// ----------------------------------------------------------------------------
module lpc_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [lpc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lpc_pkg::CFG_DATA_W-1:0]    cfg_data,
  output lpc_pkg::cfg_t                     cfg
);

  lpc_pkg::cfg_t cfg_r;

  // Register writes; the index selects one field, the data is truncated to it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.deadband      <= lpc_pkg::RST_DEADBAND;
      cfg_r.far_threshold <= lpc_pkg::RST_FAR_THRESH;
      cfg_r.up_fast_pct   <= lpc_pkg::RST_UP_FAST;
      cfg_r.up_slow_pct   <= lpc_pkg::RST_UP_SLOW;
      cfg_r.down_fast_pct <= lpc_pkg::RST_DOWN_FAST;
      cfg_r.down_slow_pct <= lpc_pkg::RST_DOWN_SLOW;
      cfg_r.min_speed     <= lpc_pkg::RST_MIN_SPEED;
      cfg_r.max_speed     <= lpc_pkg::RST_MAX_SPEED;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        lpc_pkg::CFG_DEADBAND:   cfg_r.deadband      <= cfg_data[9:0];
        lpc_pkg::CFG_FAR_THRESH: cfg_r.far_threshold <= cfg_data[14:0];
        lpc_pkg::CFG_UP_FAST:    cfg_r.up_fast_pct   <= cfg_data[6:0];
        lpc_pkg::CFG_UP_SLOW:    cfg_r.up_slow_pct   <= cfg_data[6:0];
        lpc_pkg::CFG_DOWN_FAST:  cfg_r.down_fast_pct <= cfg_data[6:0];
        lpc_pkg::CFG_DOWN_SLOW:  cfg_r.down_slow_pct <= cfg_data[6:0];
        lpc_pkg::CFG_MIN_SPEED:  cfg_r.min_speed     <= cfg_data[6:0];
        lpc_pkg::CFG_MAX_SPEED:  cfg_r.max_speed     <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

@@ hdl/lpc_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lift position controller state machine
// Homing sequence, origin and target tracking, limit stops and the choice of
// the percentage command for each beat.
// ----------------------------------------------------------------------------
module lpc_ctrl #(
  parameter int POS_WIDTH = lpc_pkg::POS_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step_en,
  input  logic [1:0]            req_type,
  input  logic [15:0]           raw_position,
  input  logic                  top_switch,
  input  logic                  bottom_switch,
  input  logic [POS_WIDTH-1:0]  target_conv,
  input  lpc_pkg::cfg_t         cfg,
  output lpc_pkg::ctrl_res_t    res
);

  // Width for distance compares: room for a difference of two positions and
  // for the 15-bit far threshold as a positive signed value.
  localparam int DW = (POS_WIDTH + 2 > 17) ? POS_WIDTH + 2 : 17;

  lpc_pkg::phase_t phase_r, phase_nxt, ph_eff;
  logic [15:0]          origin_r, origin_nxt, org_run;
  logic [POS_WIDTH-1:0] target_r, target_nxt, tgt_eff;
  logic                 travel_r, travel_nxt;
  logic                 moving_r, moving_nxt;

  logic [16:0]                 diff_run, diff_out;
  logic signed [POS_WIDTH-1:0] pos_run, pos_out, tgt_run;
  logic signed [DW-1:0]        delta, db_w, far_w;
  logic                        blocked_prev, blocked_now;
  logic [6:0]                  sel_pct, pct_s, lo, hi, span;
  logic                        sel_down, arrived;
  logic [13:0]                 prod;
  logic                        stop;

  // Phase and target after the request's own action.
  assign ph_eff  = (req_type == lpc_pkg::REQ_HOME) ? lpc_pkg::PH_UP_TOP : phase_r;
  assign tgt_eff = (req_type == lpc_pkg::REQ_SET) ? target_conv : target_r;

  // Position as seen in run mode, with the bottom switch re-zeroing the origin.
  assign org_run  = bottom_switch ? raw_position : origin_r;
  assign diff_run = {1'b0, raw_position} - {1'b0, org_run};
  assign pos_run  = POS_WIDTH'($signed(diff_run));

  assign blocked_prev = (!travel_r && top_switch) || (travel_r && bottom_switch);

  assign db_w  = $signed(DW'(cfg.deadband));
  assign far_w = $signed(DW'(cfg.far_threshold));

  // Phase decisions and the percentage command that results.
  always_comb begin
    phase_nxt  = ph_eff;
    origin_nxt = origin_r;
    target_nxt = tgt_eff;
    tgt_run    = $signed(tgt_eff);
    delta      = '0;
    sel_pct    = '0;
    sel_down   = 1'b0;
    arrived    = 1'b0;
    case (ph_eff)
      lpc_pkg::PH_UP_TOP: begin
        if (top_switch) begin
          phase_nxt = lpc_pkg::PH_DOWN_BOTTOM;
          sel_pct   = lpc_pkg::HOME_SLOW_PCT;
          sel_down  = 1'b1;
        end else begin
          sel_pct   = lpc_pkg::HOME_FAST_PCT;
        end
      end
      lpc_pkg::PH_DOWN_BOTTOM: begin
        if (bottom_switch) begin
          origin_nxt = raw_position;
          phase_nxt  = lpc_pkg::PH_UP_RELEASE;
          sel_pct    = lpc_pkg::HOME_FAST_PCT;
        end else begin
          sel_pct    = lpc_pkg::HOME_SLOW_PCT;
          sel_down   = 1'b1;
        end
      end
      lpc_pkg::PH_UP_RELEASE: begin
        if (!bottom_switch) begin
          phase_nxt  = lpc_pkg::PH_RUN;
          target_nxt = '0;
        end else begin
          sel_pct    = lpc_pkg::HOME_FAST_PCT;
        end
      end
      lpc_pkg::PH_RUN: begin
        origin_nxt = org_run;
        // A limit hit while moving freezes the target at the current position.
        if (moving_r && blocked_prev) begin
          tgt_run = pos_run;
        end
        target_nxt = tgt_run;
        delta = DW'(pos_run) - DW'(tgt_run);
        if ((delta < db_w) && (delta > -db_w)) begin
          arrived = 1'b1;
        end else if (delta > 0) begin
          sel_pct  = (delta > far_w) ? cfg.down_fast_pct : cfg.down_slow_pct;
          sel_down = 1'b1;
        end else if (delta < 0) begin
          sel_pct  = (-delta > far_w) ? cfg.up_fast_pct : cfg.up_slow_pct;
        end
      end
      default: begin
        phase_nxt = lpc_pkg::PH_IDLE;
      end
    endcase
  end

  // Drive: clamp, span, switch block and the moving flag.
  assign pct_s = lpc_pkg::sat100(sel_pct);
  assign lo    = lpc_pkg::sat100(cfg.min_speed);
  assign hi    = lpc_pkg::sat100(cfg.max_speed);
  assign span  = (hi > lo) ? hi - lo : '0;
  assign prod  = 14'(pct_s) * 14'(span);
  assign blocked_now = (!sel_down && top_switch) || (sel_down && bottom_switch);
  assign stop  = (pct_s == '0) || blocked_now;
  assign travel_nxt = (pct_s != '0) ? sel_down : travel_r;
  assign moving_nxt = !stop && !((lo == '0) && (prod < 14'd100));

  // Reported position uses the origin after this beat.
  assign diff_out = {1'b0, raw_position} - {1'b0, origin_nxt};
  assign pos_out  = POS_WIDTH'($signed(diff_out));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= lpc_pkg::PH_IDLE;
      origin_r <= '0;
      target_r <= '0;
      travel_r <= 1'b0;
      moving_r <= 1'b0;
    end else if (step_en) begin
      phase_r  <= phase_nxt;
      origin_r <= origin_nxt;
      target_r <= target_nxt;
      travel_r <= travel_nxt;
      moving_r <= moving_nxt;
    end
  end

  always_comb begin
    res.prod           = prod;
    res.stop           = stop;
    res.direction_down = travel_nxt;
    res.arrived        = arrived;
    res.homing_busy    = (phase_nxt == lpc_pkg::PH_UP_TOP) ||
                         (phase_nxt == lpc_pkg::PH_DOWN_BOTTOM) ||
                         (phase_nxt == lpc_pkg::PH_UP_RELEASE);
    res.position       = 16'(pos_out);
  end

endmodule

@@ hdl/lift_position_controller_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lift position controller core
// Bang-bang lift positioner with homing, fed by encoder and switch samples.
// ----------------------------------------------------------------------------
// Every input beat gives exactly one result beat, and a new beat can be taken
// in every clock cycle unless all stages are full and no result is taken. A beat
// passes through an input stage that scales the target (tenths of millimetre
// to counts by a reciprocal multiply), the state machine stage that also forms
// the speed product, a stage dividing it by 100, a stage holding the speed,
// and the output register that applies the duty scale. Each stage holds while
// the one after it is full and cannot move on, so the input keeps accepting
// beats while a result waits to be taken, until all five stages hold a beat.
// Configuration may only be written while no beat is in flight.
module lift_position_controller_core #(
  parameter int POS_WIDTH = lpc_pkg::POS_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input channel.
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // tdata: raw_position[15:0], top_switch[16], bottom_switch[17],
  //        target_tenth_mm[29:18], zero fill [31:30]
  input  logic [31:0]                    in_tdata,
  // tuser: req_type[1:0]
  input  logic [1:0]                     in_tuser,
  // Result channel.
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // tdata: duty[12:0], direction_down[13], arrived[14], homing_busy[15],
  //        position[31:16]
  output logic [31:0]                    out_tdata,
  // Configuration write port.
  input  logic                           cfg_wr_en,
  input  logic [lpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lpc_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam logic [63:0] TgtLim = (64'd1 << (POS_WIDTH - 1)) - 64'd1;

  lpc_pkg::cfg_t      cfg;
  lpc_pkg::ctrl_res_t ctrl_res;

  // Stage valids and readiness.
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, out_v_r;
  logic s1_rdy, s2_rdy, s3_rdy, s4_rdy, out_rdy;

  // Stage 1: captured input beat.
  logic [1:0]  s1_req_r;
  logic [15:0] s1_raw_r;
  logic        s1_top_r, s1_bot_r;
  logic [11:0] s1_tmm_r;

  // Stage 2: beat with the target already scaled.
  logic [1:0]           s2_req_r;
  logic [15:0]          s2_raw_r;
  logic                 s2_top_r, s2_bot_r;
  logic [POS_WIDTH-1:0] s2_tgt_r;

  // Stage 3 and 4: decision, then speed.
  lpc_pkg::ctrl_res_t s3_res_r;
  logic [6:0]         s4_speed_r;
  logic               s4_dir_r, s4_arr_r, s4_busy_r;
  logic [15:0]        s4_pos_r;

  // Output register.
  logic [12:0] out_duty_r;
  logic        out_dir_r, out_arr_r, out_busy_r;
  logic [15:0] out_pos_r;

  // Target scaling and clamping.
  logic [35:0]          tgt_prod;
  logic [lpc_pkg::TGT_Q_W-1:0] tgt_q;
  logic [POS_WIDTH-1:0] tgt_conv;

  // Speed from the product.
  logic [26:0] div_prod;
  logic [6:0]  quot, lo, speed_nxt;

  lpc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Ready chain: a stage can load when it is empty or its contents move on.
  assign out_rdy   = !out_v_r || out_tready;
  assign s4_rdy    = !s4_v_r || out_rdy;
  assign s3_rdy    = !s3_v_r || s4_rdy;
  assign s2_rdy    = !s2_v_r || s3_rdy;
  assign s1_rdy    = !s1_v_r || s2_rdy;
  assign in_tready = s1_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_rdy)  s1_v_r  <= in_tvalid;
      if (s2_rdy)  s2_v_r  <= s1_v_r;
      if (s3_rdy)  s3_v_r  <= s2_v_r;
      if (s4_rdy)  s4_v_r  <= s3_v_r;
      if (out_rdy) out_v_r <= s4_v_r;
    end
  end

  // Stage 1 capture.
  always_ff @(posedge clk) begin
    if (s1_rdy) begin
      s1_req_r <= in_tuser;
      s1_raw_r <= in_tdata[15:0];
      s1_top_r <= in_tdata[16];
      s1_bot_r <= in_tdata[17];
      s1_tmm_r <= in_tdata[29:18];
    end
  end

  // Target in counts, floor(p*3000/1326), clamped to the largest position.
  assign tgt_prod = 36'(s1_tmm_r) * 36'(lpc_pkg::TGT_RECIP);
  assign tgt_q    = tgt_prod[lpc_pkg::TGT_SHIFT +: lpc_pkg::TGT_Q_W];
  assign tgt_conv = (64'(tgt_q) > TgtLim) ? TgtLim[POS_WIDTH-1:0]
                                           : POS_WIDTH'(tgt_q);

  always_ff @(posedge clk) begin
    if (s2_rdy) begin
      s2_req_r <= s1_req_r;
      s2_raw_r <= s1_raw_r;
      s2_top_r <= s1_top_r;
      s2_bot_r <= s1_bot_r;
      s2_tgt_r <= tgt_conv;
    end
  end

  // Stage 2: the state machine steps once per beat leaving this stage.
  lpc_ctrl #(
    .POS_WIDTH (POS_WIDTH)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .step_en       (s2_v_r && s3_rdy),
    .req_type      (s2_req_r),
    .raw_position  (s2_raw_r),
    .top_switch    (s2_top_r),
    .bottom_switch (s2_bot_r),
    .target_conv   (s2_tgt_r),
    .cfg           (cfg),
    .res           (ctrl_res)
  );

  always_ff @(posedge clk) begin
    if (s3_rdy) begin
      s3_res_r <= ctrl_res;
    end
  end

  // Stage 3: speed = min + product/100, zero when stopped.
  assign div_prod  = 27'(s3_res_r.prod) * 27'(lpc_pkg::DIV100_RECIP);
  assign quot      = div_prod[lpc_pkg::DIV100_SHIFT +: 7];
  assign lo        = lpc_pkg::sat100(cfg.min_speed);
  assign speed_nxt = s3_res_r.stop ? '0 : lo + quot;

  always_ff @(posedge clk) begin
    if (s4_rdy) begin
      s4_speed_r <= speed_nxt;
      s4_dir_r   <= s3_res_r.direction_down;
      s4_arr_r   <= s3_res_r.arrived;
      s4_busy_r  <= s3_res_r.homing_busy;
      s4_pos_r   <= s3_res_r.position;
    end
  end

  // Output register with the duty scale applied.
  always_ff @(posedge clk) begin
    if (out_rdy) begin
      out_duty_r <= 13'(s4_speed_r) * lpc_pkg::DUTY_PER_SPEED;
      out_dir_r  <= s4_dir_r;
      out_arr_r  <= s4_arr_r;
      out_busy_r <= s4_busy_r;
      out_pos_r  <= s4_pos_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {out_pos_r, out_busy_r, out_arr_r, out_dir_r, out_duty_r};

endmodule
